@@ design/idr_pkg.sv @@
// Package for the 64-bit signed/unsigned divide-remainder block.
// Holds the data width, opcode and state encodings, and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package idr_pkg;

  localparam int DATA_W = 64;
  localparam int CNT_W  = $clog2(DATA_W);

  typedef enum logic [1:0] {
    OP_UQUOT = 2'd0,
    OP_UREM  = 2'd1,
    OP_SQUOT = 2'd2,
    OP_SREM  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

@@ design/int64_divide_remainder_top.sv @@
// Top level of the 64-bit divide-remainder block.
// Joins idr_ctrl and idr_dpath; depends on idr_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries op, dividend and divisor.
//   op selects unsigned quotient, unsigned remainder, signed quotient or
//   signed remainder. A zero divisor returns 0 in every mode; the most
//   negative value over minus one returns the most negative value as a
//   signed quotient and 0 as a signed remainder. Output channel
//   (out_valid / out_stall) carries one result per transaction.
//   Each transaction takes DATA_W = 64 iterations of the shared
//   shift-subtract unit, then a fix-up state that negates and registers
//   the result. in_stall is low only while the controller is idle, so a
//   new input is taken only after the previous one leaves the fix-up state.
//   A finished result sits in the output register while the next input is
//   accepted and iterated. If the receiver still stalls when the next result
//   is ready, the block holds in its fix-up state until the register frees.
//   Reset (rst, synchronous, active high) returns to idle and drops any
//   pending result.
`timescale 1ns / 1ps

module int64_divide_remainder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result
);

  idr_pkg::cmd_t                 cmd;
  idr_pkg::status_t              status;
  logic [idr_pkg::DATA_W-1:0]    res_w;

  idr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  idr_dpath u_dpath (
    .clk      (clk),
    .cmd      (cmd),
    .status   (status),
    .op       (op),
    .dividend (dividend[idr_pkg::DATA_W-1:0]),
    .divisor  (divisor[idr_pkg::DATA_W-1:0]),
    .result   (res_w)
  );

  assign result = 64'(res_w);

endmodule

@@ design/idr_ctrl.sv @@
// Controller state machine for the divide-remainder block.
// Sequences load, iteration and result write; owns the output valid flag.
// Depends on idr_pkg.
`timescale 1ns / 1ps

module idr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  idr_pkg::status_t status,
  output idr_pkg::cmd_t    cmd
);

  idr_pkg::state_t state;
  idr_pkg::state_t state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= idr_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    cmd            = '0;
    in_stall       = 1'b1;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      idr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = idr_pkg::ST_RUN;
        end
      end
      idr_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last) begin
          state_next = idr_pkg::ST_FIN;
        end
      end
      idr_pkg::ST_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = idr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = idr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/idr_dpath.sv @@
// Datapath for the divide-remainder block: sign handling, restoring
// shift-subtract iteration, result fix-up and output register.
// Depends on idr_pkg.
`timescale 1ns / 1ps

module idr_dpath (
  input  logic                       clk,
  input  idr_pkg::cmd_t              cmd,
  output idr_pkg::status_t           status,
  input  logic [1:0]                 op,
  input  logic [idr_pkg::DATA_W-1:0] dividend,
  input  logic [idr_pkg::DATA_W-1:0] divisor,
  output logic [idr_pkg::DATA_W-1:0] result
);

  localparam int W = idr_pkg::DATA_W;

  logic [W-1:0]              rem;
  logic [W-1:0]              quot;
  logic [W-1:0]              den;
  logic [idr_pkg::CNT_W-1:0] cnt;
  logic                      want_rem;
  logic                      neg_q;
  logic                      neg_r;
  logic                      zero_b;

  logic         is_signed;
  logic         neg_a;
  logic         neg_b;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [W-1:0] shifted;
  logic [W:0]   diff;
  logic         take;
  logic [W-1:0] sel;
  logic         neg_sel;

  always_comb begin
    is_signed = (op == idr_pkg::OP_SQUOT) || (op == idr_pkg::OP_SREM);
    neg_a     = is_signed && dividend[W-1];
    neg_b     = is_signed && divisor[W-1];
    mag_a     = neg_a ? (W'(0) - dividend) : dividend;
    mag_b     = neg_b ? (W'(0) - divisor) : divisor;
    shifted   = {rem[W-2:0], quot[W-1]};
    diff      = {1'b0, shifted} - {1'b0, den};
    take      = rem[W-1] || !diff[W];
    sel       = want_rem ? rem : quot;
    neg_sel   = want_rem ? neg_r : neg_q;
  end

  assign status.last = (cnt == idr_pkg::CNT_W'(W - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot     <= mag_a;
      den      <= mag_b;
      rem      <= '0;
      cnt      <= '0;
      want_rem <= (op == idr_pkg::OP_UREM) || (op == idr_pkg::OP_SREM);
      neg_q    <= neg_a ^ neg_b;
      neg_r    <= neg_a;
      zero_b   <= (divisor == '0);
    end else if (cmd.step) begin
      rem  <= take ? diff[W-1:0] : shifted;
      quot <= {quot[W-2:0], take};
      cnt  <= cnt + 1'b1;
    end
    if (cmd.finish) begin
      result <= zero_b ? '0 : (neg_sel ? (W'(0) - sel) : sel);
    end
  end

endmodule

@@ design/idr_checker.sv @@
// Port-level checker for the divide-remainder block, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module idr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] result
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(result))
    else $error("result changed while stalled");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in progress");

  a_busy_span: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall [*65])
    else $error("input taken again before the iteration finished");

endmodule

bind int64_divide_remainder_top idr_checker u_idr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .result    (result)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for int64_divide_remainder_top: queue-fed driver,
// clocked monitor and a quotient/remainder predictor checked per transaction.
// Depends on idr_pkg and the int64_divide_remainder_top RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int          NUM_RANDOM    = 1250;
  localparam int          HOLD_AT       = 150;
  localparam int          HOLD_CYCLES   = 500;
  localparam int          PAUSE_AT      = 700;
  localparam int          DRAIN_CYCLES  = 80;
  localparam longint      LIMIT_NS      = 64'd20_000_000;
  localparam logic [63:0] MOST_NEG      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    idr_pkg::op_t op;
    logic [63:0]  dividend;
    logic [63:0]  divisor;
  } div_request_t;

  typedef struct {
    logic [63:0]  value;
    div_request_t req;
  } div_expect_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [1:0]  op        = idr_pkg::OP_UQUOT;
  logic [63:0] dividend  = '0;
  logic [63:0] divisor   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result;

  div_request_t pending_requests[$];
  div_expect_t  expected_results[$];
  int           n_total  = 0;
  int           n_sent   = 0;
  int           n_recv   = 0;
  int           n_errors = 0;

  int  hold_count = 0;
  bit  hold_done  = 0;
  bit  pausing    = 0;
  bit  pause_done = 0;

  int64_divide_remainder_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .dividend  (dividend),
    .divisor   (divisor),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  function automatic logic [63:0] predict_quot_rem(idr_pkg::op_t opc, logic [63:0] a_in,
                                                   logic [63:0] b_in);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] res;
    logic        sgn;
    logic        neg_a;
    logic        neg_b;
    a     = a_in;
    b     = b_in;
    sgn   = (opc == idr_pkg::OP_SQUOT) || (opc == idr_pkg::OP_SREM);
    neg_a = sgn && a[63];
    neg_b = sgn && b[63];
    if (neg_a) a = -a;
    if (neg_b) b = -b;
    q = '0;
    r = '0;
    if (b != '0) begin
      q = a / b;
      r = a % b;
    end
    if ((opc == idr_pkg::OP_UREM) || (opc == idr_pkg::OP_SREM)) begin
      res = neg_a ? -r : r;
    end else begin
      res = (neg_a != neg_b) ? -q : q;
    end
    return res;
  endfunction

  function automatic logic [63:0] shaped_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      3, 4: v = v >> $urandom_range(1, 63);
      5: v = -(v >> $urandom_range(1, 63));
      6: v = v & 64'hFF;
      7: v = v[0] ? MOST_NEG : ALL_ONES;
      default: ;
    endcase
    return v;
  endfunction

  function automatic int idle_pct(int sent, bit sender);
    if (sent < n_total / 3) return sender ? 14 : 47;
    if (sent < (2 * n_total) / 3) return sender ? 47 : 14;
    return 0;
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    logic [63:0]  dvd[6];
    logic [63:0]  dvs[6];
    div_request_t req;
    dvd[0] = ALL_ONES;       dvs[0] = '0;
    dvd[1] = MOST_NEG;       dvs[1] = ALL_ONES;
    dvd[2] = ALL_ONES;       dvs[2] = 64'd1;
    dvd[3] = '0;             dvs[3] = ALL_ONES;
    dvd[4] = -64'sd7;        dvs[4] = 64'd2;
    dvd[5] = 64'd7;          dvs[5] = MOST_NEG;
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 6; c++) begin
        req.op       = idr_pkg::op_t'(k);
        req.dividend = dvd[c];
        req.divisor  = dvs[c];
        pending_requests.push_back(req);
      end
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      req.op       = idr_pkg::op_t'($urandom_range(0, 3));
      req.dividend = shaped_operand();
      req.divisor  = ($urandom_range(0, 31) == 0) ? '0 : shaped_operand();
      pending_requests.push_back(req);
    end
    n_total = pending_requests.size();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (!(n_sent == n_total && n_recv == n_total));
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("int64_divide_remainder_top test passed");
    end else begin
      $display("int64_divide_remainder_top test failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("int64_divide_remainder_top test failed");
    $finish;
  end

  // Driver: hold a stalled transaction, otherwise offer the next pending one.
  always @(posedge clk) begin
    bit          take;
    bit          offer;
    int          next_sent;
    div_expect_t e;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take      = in_valid && !in_stall;
      next_sent = n_sent + (take ? 1 : 0);
      if (take) begin
        e.req.op       = idr_pkg::op_t'(op);
        e.req.dividend = dividend;
        e.req.divisor  = divisor;
        e.value        = predict_quot_rem(idr_pkg::op_t'(op), dividend, divisor);
        expected_results.push_back(e);
        void'(pending_requests.pop_front());
        n_sent <= next_sent;
      end
      if (!pause_done && next_sent >= PAUSE_AT) begin
        pausing    = 1;
        pause_done = 1;
      end
      if (pausing && n_recv == next_sent) pausing = 0;
      if (!(in_valid && !take)) begin
        offer = (pending_requests.size() > 0) && !pausing &&
                ($urandom_range(0, 99) >= idle_pct(next_sent, 1));
        if (offer) begin
          in_valid <= 1'b1;
          op       <= pending_requests[0].op;
          dividend <= pending_requests[0].dividend;
          divisor  <= pending_requests[0].divisor;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off to back the block up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_count > 0) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count - 1;
    end else if (!hold_done && n_sent >= HOLD_AT) begin
      out_stall  <= 1'b1;
      hold_count <= HOLD_CYCLES;
      hold_done  <= 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_pct(n_sent, 0));
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    div_expect_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result);
        n_errors++;
      end else begin
        e = expected_results.pop_front();
        n_recv <= n_recv + 1;
        if (result !== e.value) begin
          $display("%0t: %s %h / %h mismatch, expected %h, actual %h", $time,
                   e.req.op.name(), e.req.dividend, e.req.divisor, e.value, result);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && n_sent == n_total && n_recv == n_total && expected_results.size() != 0) begin
      $display("%0t: leftover expectation, expected %h, actual none", $time,
               expected_results[0].value);
      n_errors++;
      void'(expected_results.pop_front());
    end
  end

endmodule

@@ int64_divide_remainder_top.f @@
design/idr_pkg.sv
design/idr_ctrl.sv
design/idr_dpath.sv
design/int64_divide_remainder_top.sv
design/idr_checker.sv
verif/tb_top.sv
